@@ rtl/nds_pkg.sv @@
`timescale 1ns / 1ps
// Package for the nixie digit shift driver.
// Chain, tube and queue sizes, limits and entry types; no dependencies.
package nds_pkg;

    localparam int SHIFT_BYTES = 8;
    localparam int CHAIN_BITS  = SHIFT_BYTES * 8;
    localparam int CNT_W       = $clog2(CHAIN_BITS);
    localparam int TUBE_COUNT  = 6;
    localparam int TUBE_SPAN   = 10;
    localparam logic [7:0] DIGIT_MAX = 8'd9;
    localparam logic [3:0] COLON_MAX = 4'd3;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CHAIN_BITS-1:0] map;
        logic [3:0]            dots;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

endpackage

@@ rtl/nds_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frames in and serial bits out.
// No dependencies.
interface nds_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_0;
    logic [7:0] digit_1;
    logic [7:0] digit_2;
    logic [7:0] digit_3;
    logic [7:0] digit_4;
    logic [7:0] digit_5;
    logic [7:0] dot_code;

    modport source (output valid, digit_0, digit_1, digit_2, digit_3, digit_4,
                    digit_5, dot_code, input ready);
    modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, digit_4,
                    digit_5, dot_code, output ready);
endinterface

interface nds_bit_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_strobe;
    logic left_bottom_dot;
    logic left_top_dot;
    logic right_bottom_dot;
    logic right_top_dot;

    modport source (output valid, serial_bit, latch_strobe, left_bottom_dot,
                    left_top_dot, right_bottom_dot, right_top_dot, input ready);
    modport sink   (input valid, serial_bit, latch_strobe, left_bottom_dot,
                    left_top_dot, right_bottom_dot, right_top_dot, output ready);
endinterface

@@ rtl/nixie_digit_shift_driver.sv @@
`timescale 1ns / 1ps
// Top level of the nixie digit shift driver.
// Depends on nds_pkg, nds_if, nds_front, nds_queue and nds_shifter.
//
// i_frame takes one display frame per transaction: six digit bytes, hours
// tens first, and a dot code byte. Digits above 9 blank their tube; a colon
// nibble above 3 leaves that colon unchanged.
// o_bits gives 64 transactions per frame (SHIFT_BYTES*8), cathode map bit 63
// first; latch_strobe is high on the last one. Every transaction carries the
// four colon dot drives as set by its frame.
// With the shifter idle, an accepted frame is first written into the queue
// and then loaded into the shifter, whose valid goes high with its first bit.
// Throughput: one bit per cycle while o_bits.ready is high, and frames
// back to back; the rate is set by the shift register in the back end.
// A two-entry queue sits between front end and shifter, so up to two more
// frames are accepted while one is shifting.
// Reset (i_rst_n low at a clock edge) empties the queue, stops the shifter
// and clears the front end's dot state; the dot outputs are not reset.
// When the receiver holds ready low, the current bit holds and the shifter
// stops; i_frame.ready drops once the queue is full.
module nixie_digit_shift_driver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nds_frame_if.sink i_frame,
    nds_bit_if.source o_bits
);
    import nds_pkg::*;

    t_push  w_push;
    logic   w_push_ready;
    logic   w_pop_valid;
    t_entry w_pop_entry;
    logic   w_pop;

    nds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (i_frame),
        .i_push_ready (w_push_ready),
        .o_push       (w_push)
    );

    nds_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_entry  (w_pop_entry),
        .i_pop        (w_pop)
    );

    nds_shifter u_shifter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_entry (w_pop_entry),
        .o_pop       (w_pop),
        .o_bits      (o_bits)
    );

endmodule

@@ rtl/nds_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts frames, builds the cathode map and updates the dot drives.
// Depends on nds_pkg and nds_if.
module nds_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nds_frame_if.sink         i_frame,
    input  logic              i_push_ready,
    output nds_pkg::t_push    o_push
);
    import nds_pkg::*;

    logic [3:0]            r_dot_pins;
    logic [3:0]            n_dot_pins;
    logic [7:0]            w_dig [TUBE_COUNT];
    logic [CHAIN_BITS-1:0] w_map;
    logic                  w_take;

    assign w_dig[0] = i_frame.digit_5;
    assign w_dig[1] = i_frame.digit_4;
    assign w_dig[2] = i_frame.digit_3;
    assign w_dig[3] = i_frame.digit_2;
    assign w_dig[4] = i_frame.digit_1;
    assign w_dig[5] = i_frame.digit_0;

    assign i_frame.ready = i_push_ready;
    assign w_take        = i_frame.valid && i_push_ready;

    always_comb begin
        w_map = '0;
        for (int t = 0; t < TUBE_COUNT; t++) begin
            if (w_dig[t] <= DIGIT_MAX) begin
                w_map[t * TUBE_SPAN + int'(w_dig[t][3:0])] = 1'b1;
            end
        end
    end

    // codes above 3 keep the colon as it is
    always_comb begin
        n_dot_pins = r_dot_pins;
        if (i_frame.dot_code[7:4] <= COLON_MAX) begin
            n_dot_pins[1:0] = i_frame.dot_code[5:4];
        end
        if (i_frame.dot_code[3:0] <= COLON_MAX) begin
            n_dot_pins[3:2] = i_frame.dot_code[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_pins <= 4'd0;
        end else if (w_take) begin
            r_dot_pins <= n_dot_pins;
        end
    end

    assign o_push.valid      = i_frame.valid;
    assign o_push.entry.map  = w_map;
    assign o_push.entry.dots = n_dot_pins;

endmodule

@@ rtl/nds_queue.sv @@
`timescale 1ns / 1ps
// Short frame queue between front end and shifter.
// Depends on nds_pkg.
module nds_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nds_pkg::t_push    i_push,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output nds_pkg::t_entry   o_pop_entry,
    input  logic              i_pop
);
    import nds_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign w_wr         = i_push.valid && o_push_ready;
    assign w_rd         = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/nds_shifter.sv @@
`timescale 1ns / 1ps
// Back end: shifts each queued cathode map out MSB first, strobing the last bit.
// Depends on nds_pkg and nds_if.
module nds_shifter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  nds_pkg::t_entry   i_pop_entry,
    output logic              o_pop,
    nds_bit_if.source         o_bits
);
    import nds_pkg::*;

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [CHAIN_BITS-1:0] r_map;
    logic [3:0]            r_dots;
    logic                  w_last;
    logic                  w_fire;
    logic                  w_load;

    assign w_last = (r_cnt == CNT_W'(CHAIN_BITS - 1));
    assign w_fire = r_busy && o_bits.ready;
    assign w_load = !r_busy || (w_fire && w_last);
    assign o_pop  = w_load && i_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_busy <= i_pop_valid;
            r_cnt  <= '0;
        end else if (w_fire) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_map  <= i_pop_entry.map;
            r_dots <= i_pop_entry.dots;
        end else if (w_fire) begin
            r_map <= {r_map[CHAIN_BITS-2:0], 1'b0};
        end
    end

    assign o_bits.valid            = r_busy;
    assign o_bits.serial_bit       = r_map[CHAIN_BITS-1];
    assign o_bits.latch_strobe     = w_last;
    assign o_bits.left_bottom_dot  = r_dots[0];
    assign o_bits.left_top_dot     = r_dots[1];
    assign o_bits.right_bottom_dot = r_dots[2];
    assign o_bits.right_top_dot    = r_dots[3];

endmodule

@@ tb/nixie_digit_shift_driver_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nixie_digit_shift_driver: frames in, serial bits out.
// Predicts each frame's 64 bit transactions and dot drives; uses nds_pkg and nds_if.
module nixie_digit_shift_driver_tb;
    import nds_pkg::*;

    typedef struct packed {
        logic [5:0][7:0] digit;
        logic [7:0]      dot_code;
    } t_frame;

    typedef struct packed {
        logic       serial;
        logic       latch;
        logic [3:0] dots;
    } t_chain_bit;

    logic i_clk;
    logic i_rst_n;

    nds_frame_if frame_if ();
    nds_bit_if   bits_if ();

    nixie_digit_shift_driver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_if),
        .o_bits  (bits_if)
    );

    t_frame     pending_frames[$];
    t_chain_bit expected_bits[$];
    logic [3:0] dot_state;
    t_chain_bit want;

    int errors;
    int frames_sent;
    int bits_checked;
    int blank_tubes;
    int kept_colons;
    logic calm;

    assign calm = (frames_sent >= 150) && (frames_sent < 230);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(6_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic got, input logic exp_val);
        errors++;
        $display("mismatch at bit %0d (%0t): %s got %b, expected %b",
                 bits_checked, $realtime, field, got, exp_val);
    endtask

    task automatic predict_frame(input t_frame f);
        logic [CHAIN_BITS-1:0] cathodes;
        logic [3:0]            nib;
        t_chain_bit            b;
        cathodes = '0;
        for (int c = 0; c < 2; c++) begin
            nib = c == 0 ? f.dot_code[7:4] : f.dot_code[3:0];
            if (nib <= COLON_MAX)
                dot_state[2*c +: 2] = nib[1:0];
            else
                kept_colons++;
        end
        for (int t = 0; t < TUBE_COUNT; t++) begin
            if (f.digit[TUBE_COUNT-1-t] <= DIGIT_MAX)
                cathodes[t*TUBE_SPAN + f.digit[TUBE_COUNT-1-t]] = 1'b1;
            else
                blank_tubes++;
        end
        for (int k = 0; k < CHAIN_BITS; k++) begin
            b.serial = cathodes[CHAIN_BITS-1-k];
            b.latch  = (k == CHAIN_BITS-1);
            b.dots   = dot_state;
            expected_bits.push_back(b);
        end
    endtask

    // digits packed with digit_5 in the top byte, digit_0 in the bottom byte
    task automatic add_frame(input logic [47:0] digits, input logic [7:0] dc);
        t_frame f;
        f.digit    = digits;
        f.dot_code = dc;
        pending_frames.push_back(f);
    endtask

    function automatic logic [7:0] rand_digit();
        return $urandom_range(99) < 75 ? 8'($urandom_range(9)) : 8'($urandom_range(255));
    endfunction

    function automatic logic [3:0] rand_colon();
        return $urandom_range(99) < 80 ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    endfunction

    // frame driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                predict_frame({frame_if.digit_5, frame_if.digit_4, frame_if.digit_3,
                               frame_if.digit_2, frame_if.digit_1, frame_if.digit_0,
                               frame_if.dot_code});
                frames_sent++;
            end
            if (!frame_if.valid || frame_if.ready) begin
                if (pending_frames.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
                    t_frame f;
                    f = pending_frames.pop_front();
                    frame_if.digit_0  <= f.digit[0];
                    frame_if.digit_1  <= f.digit[1];
                    frame_if.digit_2  <= f.digit[2];
                    frame_if.digit_3  <= f.digit[3];
                    frame_if.digit_4  <= f.digit[4];
                    frame_if.digit_5  <= f.digit[5];
                    frame_if.dot_code <= f.dot_code;
                    frame_if.valid    <= 1'b1;
                end else begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    // bit monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bits_if.ready <= 1'b0;
        end else begin
            if (bits_if.valid && bits_if.ready) begin
                if (expected_bits.size() == 0) begin
                    errors++;
                    $display("unexpected bit transaction at %0t", $realtime);
                end else begin
                    want = expected_bits.pop_front();
                    if (bits_if.serial_bit !== want.serial)
                        report_mismatch("serial_bit", bits_if.serial_bit, want.serial);
                    if (bits_if.latch_strobe !== want.latch)
                        report_mismatch("latch_strobe", bits_if.latch_strobe, want.latch);
                    if (bits_if.left_bottom_dot !== want.dots[0])
                        report_mismatch("left_bottom_dot", bits_if.left_bottom_dot,
                                        want.dots[0]);
                    if (bits_if.left_top_dot !== want.dots[1])
                        report_mismatch("left_top_dot", bits_if.left_top_dot, want.dots[1]);
                    if (bits_if.right_bottom_dot !== want.dots[2])
                        report_mismatch("right_bottom_dot", bits_if.right_bottom_dot,
                                        want.dots[2]);
                    if (bits_if.right_top_dot !== want.dots[3])
                        report_mismatch("right_top_dot", bits_if.right_top_dot,
                                        want.dots[3]);
                    bits_checked++;
                end
            end
            bits_if.ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    initial begin
        t_frame f;
        errors       = 0;
        frames_sent  = 0;
        bits_checked = 0;
        blank_tubes  = 0;
        kept_colons  = 0;
        dot_state    = '0;
        i_rst_n      = 1'b0;
        frame_if.valid    = 1'b0;
        frame_if.digit_0  = '0;
        frame_if.digit_1  = '0;
        frame_if.digit_2  = '0;
        frame_if.digit_3  = '0;
        frame_if.digit_4  = '0;
        frame_if.digit_5  = '0;
        frame_if.dot_code = '0;
        bits_if.ready     = 1'b0;

        add_frame(48'h00_00_00_00_00_00, 8'h00);
        add_frame(48'h09_09_09_09_09_09, 8'h33);
        add_frame(48'hFF_FF_FF_FF_FF_FF, 8'h44);
        add_frame(48'h0A_0A_0A_0A_0A_0A, 8'h11);
        add_frame(48'h80_80_80_80_80_80, 8'h22);
        add_frame(48'hFF_00_7F_09_0A_01, 8'hC2);
        for (int k = 0; k < 10; k++) begin
            for (int i = 0; i < 6; i++)
                f.digit[i] = 8'((i + k) % 10);
            case (k)
                0: f.dot_code = 8'h01;
                1: f.dot_code = 8'h10;
                2: f.dot_code = 8'h02;
                3: f.dot_code = 8'h20;
                4: f.dot_code = 8'h03;
                5: f.dot_code = 8'h30;
                6: f.dot_code = 8'hF0;
                7: f.dot_code = 8'h0F;
                8: f.dot_code = 8'h5A;
                default: f.dot_code = 8'h3C;
            endcase
            pending_frames.push_back(f);
        end
        for (int n = 0; n < 384; n++) begin
            for (int i = 0; i < 6; i++)
                f.digit[i] = rand_digit();
            f.dot_code = {rand_colon(), rand_colon()};
            pending_frames.push_back(f);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_frames.size() != 0 || frame_if.valid)
            @(posedge i_clk);
        while (expected_bits.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d frames shifted out as %0d checked bit transactions",
                 frames_sent, bits_checked);
        $display("%0d tubes blanked, %0d colon codes left the dots unchanged",
                 blank_tubes, kept_colons);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/nds_pkg.sv
rtl/nds_if.sv
rtl/nds_front.sv
rtl/nds_queue.sv
rtl/nds_shifter.sv
rtl/nixie_digit_shift_driver.sv
tb/nixie_digit_shift_driver_tb.sv
